// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros used by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rvdec_pkg.sv =====
// ============================================================================
// rvdec_pkg
// Types and codes for the RV32 instruction decoder.
// ============================================================================
package rvdec_pkg;

    localparam logic [2:0] FK_NONE = 3'd0;
    localparam logic [2:0] FK_R    = 3'd1;
    localparam logic [2:0] FK_I    = 3'd2;
    localparam logic [2:0] FK_S    = 3'd3;
    localparam logic [2:0] FK_B    = 3'd4;
    localparam logic [2:0] FK_U    = 3'd5;
    localparam logic [2:0] FK_J    = 3'd6;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_AMO    = 7'h2F;
    localparam logic [6:0] OPC_OPFP   = 7'h53;
    localparam logic [6:0] OPC_MADD   = 7'h43;
    localparam logic [6:0] OPC_MSUB   = 7'h47;
    localparam logic [6:0] OPC_NMSUB  = 7'h4B;
    localparam logic [6:0] OPC_NMADD  = 7'h4F;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_LOADFP = 7'h07;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_STFP   = 7'h27;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MUL  = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [3:0] FM_TSO  = 4'b1000;
    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;
    localparam logic [11:0] SYS_WFI    = 12'h105;
    localparam logic [11:0] SYS_MRET   = 12'h302;

    typedef enum logic [6:0] {
        OC_NONE, OC_LUI, OC_AUIPC, OC_JAL, OC_JALR, OC_BEQ, OC_BNE, OC_BLT, OC_BGE,
        OC_BLTU, OC_BGEU, OC_LB, OC_LH, OC_LW, OC_LBU, OC_LHU, OC_SB, OC_SH, OC_SW,
        OC_ADDI, OC_SLTI, OC_SLTIU, OC_XORI, OC_ORI, OC_ANDI, OC_SLLI, OC_SRLI, OC_SRAI,
        OC_ADD, OC_SUB, OC_SLL, OC_SLT, OC_SLTU, OC_XOR, OC_SRL, OC_SRA, OC_OR, OC_AND,
        OC_FENCE, OC_FENCETSO, OC_ECALL, OC_EBREAK,
        OC_CSRRW, OC_CSRRS, OC_CSRRC, OC_CSRRWI, OC_CSRRSI, OC_CSRRCI,
        OC_MUL, OC_MULH, OC_MULHSU, OC_MULHU, OC_DIV, OC_DIVU, OC_REM, OC_REMU,
        OC_LRW, OC_SCW, OC_AMOSWAPW, OC_AMOADDW, OC_AMOXORW, OC_AMOANDW, OC_AMOORW,
        OC_AMOMINW, OC_AMOMAXW, OC_AMOMINUW, OC_AMOMAXUW,
        OC_FLW, OC_FSW, OC_FMADDS, OC_FMSUBS, OC_FNMSUBS, OC_FNMADDS, OC_FADDS, OC_FSUBS,
        OC_FMULS, OC_FDIVS, OC_FSQRTS, OC_FSGNJS, OC_FSGNJNS, OC_FSGNJXS, OC_FMINS,
        OC_FMAXS, OC_FCVTWS, OC_FCVTWUS, OC_FMVXW, OC_FEQS, OC_FLTS, OC_FLES, OC_FCLASSS,
        OC_FCVTSW, OC_FCVTSWU, OC_FMVWX,
        OC_FLD, OC_FSD, OC_FMADDD, OC_FMSUBD, OC_FNMSUBD, OC_FNMADDD, OC_FADDD, OC_FSUBD,
        OC_FMULD, OC_FDIVD, OC_FSQRTD, OC_FSGNJD, OC_FSGNJND, OC_FSGNJXD, OC_FMIND,
        OC_FMAXD, OC_FCVTSD, OC_FCVTDS, OC_FEQD, OC_FLTD, OC_FLED, OC_FCLASSD,
        OC_FCVTWD, OC_FCVTWUD, OC_FCVTDW, OC_FCVTDWU,
        OC_FENCEI, OC_WFI, OC_MRET
    } t_opcode;

    typedef struct packed {
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rs2;
        logic [11:0] imm12;
        logic [3:0]  fm;
    } t_fields;

    typedef struct packed {
        logic        sel_s;    // precision picked single
        logic        sel_d;    // precision picked double
        t_opcode     op_s;     // single-precision or fixed candidate
        t_opcode     op_d;     // double-precision candidate
    } t_cand;

    typedef struct packed {
        logic [6:0]  opcode;
        logic [2:0]  format;
        logic [20:0] imm;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [4:0]  rs3;
        logic [2:0]  rm;
        logic        aq;
        logic        rl;
    } t_result;

endpackage

// ===== hw/rtl/rvdec_if.sv =====
// ============================================================================
// rvdec_word_if
// Valid/ready channel carrying one word.
// ============================================================================
interface rvdec_word_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rvdec_opsel.sv =====
// ============================================================================
// rvdec_opsel
// Candidate operation codes from major opcode, funct3, funct7 and rs2.
// ============================================================================
module rvdec_opsel
    import rvdec_pkg::*;
(
    input  t_fields i_fld,
    output t_cand   o_cand
);
    logic [4:0] f5;
    logic [1:0] prec;

    assign f5   = i_fld.f7[6:2];
    assign prec = i_fld.f7[1:0];

    always_comb begin
        o_cand.op_s  = OC_NONE;
        o_cand.op_d  = OC_NONE;
        o_cand.sel_s = 1'b1;
        o_cand.sel_d = 1'b0;
        unique case (i_fld.opc)
            OPC_OP: begin
                if (i_fld.f7 == F7_BASE) begin
                    case (i_fld.f3)
                        3'd0: o_cand.op_s = OC_ADD;
                        3'd1: o_cand.op_s = OC_SLL;
                        3'd2: o_cand.op_s = OC_SLT;
                        3'd3: o_cand.op_s = OC_SLTU;
                        3'd4: o_cand.op_s = OC_XOR;
                        3'd5: o_cand.op_s = OC_SRL;
                        3'd6: o_cand.op_s = OC_OR;
                        default: o_cand.op_s = OC_AND;
                    endcase
                end else if (i_fld.f7 == F7_MUL) begin
                    case (i_fld.f3)
                        3'd0: o_cand.op_s = OC_MUL;
                        3'd1: o_cand.op_s = OC_MULH;
                        3'd2: o_cand.op_s = OC_MULHSU;
                        3'd3: o_cand.op_s = OC_MULHU;
                        3'd4: o_cand.op_s = OC_DIV;
                        3'd5: o_cand.op_s = OC_DIVU;
                        3'd6: o_cand.op_s = OC_REM;
                        default: o_cand.op_s = OC_REMU;
                    endcase
                end else if (i_fld.f7 == F7_ALT) begin
                    if (i_fld.f3 == 3'd0) o_cand.op_s = OC_SUB;
                    else if (i_fld.f3 == 3'd5) o_cand.op_s = OC_SRA;
                end
            end
            OPC_OPIMM: begin
                case (i_fld.f3)
                    3'd0: o_cand.op_s = OC_ADDI;
                    3'd1: o_cand.op_s = (i_fld.f7 == F7_BASE) ? OC_SLLI : OC_NONE;
                    3'd2: o_cand.op_s = OC_SLTI;
                    3'd3: o_cand.op_s = OC_SLTIU;
                    3'd4: o_cand.op_s = OC_XORI;
                    3'd5: o_cand.op_s = (i_fld.f7 == F7_BASE) ? OC_SRLI :
                                        (i_fld.f7 == F7_ALT) ? OC_SRAI : OC_NONE;
                    3'd6: o_cand.op_s = OC_ORI;
                    default: o_cand.op_s = OC_ANDI;
                endcase
            end
            OPC_LOAD: begin
                case (i_fld.f3)
                    3'd0: o_cand.op_s = OC_LB;
                    3'd1: o_cand.op_s = OC_LH;
                    3'd2: o_cand.op_s = OC_LW;
                    3'd4: o_cand.op_s = OC_LBU;
                    3'd5: o_cand.op_s = OC_LHU;
                    default: o_cand.op_s = OC_NONE;
                endcase
            end
            OPC_STORE: begin
                case (i_fld.f3)
                    3'd0: o_cand.op_s = OC_SB;
                    3'd1: o_cand.op_s = OC_SH;
                    3'd2: o_cand.op_s = OC_SW;
                    default: o_cand.op_s = OC_NONE;
                endcase
            end
            OPC_BRANCH: begin
                case (i_fld.f3)
                    3'd0: o_cand.op_s = OC_BEQ;
                    3'd1: o_cand.op_s = OC_BNE;
                    3'd4: o_cand.op_s = OC_BLT;
                    3'd5: o_cand.op_s = OC_BGE;
                    3'd6: o_cand.op_s = OC_BLTU;
                    3'd7: o_cand.op_s = OC_BGEU;
                    default: o_cand.op_s = OC_NONE;
                endcase
            end
            OPC_JAL:   o_cand.op_s = OC_JAL;
            OPC_JALR:  o_cand.op_s = (i_fld.f3 == 3'd0) ? OC_JALR : OC_NONE;
            OPC_LUI:   o_cand.op_s = OC_LUI;
            OPC_AUIPC: o_cand.op_s = OC_AUIPC;
            OPC_FENCE: begin
                if (i_fld.f3 == 3'd0)
                    o_cand.op_s = (i_fld.fm == FM_TSO) ? OC_FENCETSO : OC_FENCE;
                else if (i_fld.f3 == 3'd1)
                    o_cand.op_s = OC_FENCEI;
            end
            OPC_SYSTEM: begin
                case (i_fld.f3)
                    3'd0: begin
                        case (i_fld.imm12)
                            SYS_ECALL:  o_cand.op_s = OC_ECALL;
                            SYS_EBREAK: o_cand.op_s = OC_EBREAK;
                            SYS_WFI:    o_cand.op_s = OC_WFI;
                            SYS_MRET:   o_cand.op_s = OC_MRET;
                            default:    o_cand.op_s = OC_NONE;
                        endcase
                    end
                    3'd1: o_cand.op_s = OC_CSRRW;
                    3'd2: o_cand.op_s = OC_CSRRS;
                    3'd3: o_cand.op_s = OC_CSRRC;
                    3'd5: o_cand.op_s = OC_CSRRWI;
                    3'd6: o_cand.op_s = OC_CSRRSI;
                    3'd7: o_cand.op_s = OC_CSRRCI;
                    default: o_cand.op_s = OC_NONE;
                endcase
            end
            OPC_AMO: begin
                if (i_fld.f3 == 3'd2) begin
                    case (f5)
                        5'h00: o_cand.op_s = OC_AMOADDW;
                        5'h01: o_cand.op_s = OC_AMOSWAPW;
                        5'h02: o_cand.op_s = (i_fld.rs2 == 5'd0) ? OC_LRW : OC_NONE;
                        5'h03: o_cand.op_s = OC_SCW;
                        5'h04: o_cand.op_s = OC_AMOXORW;
                        5'h08: o_cand.op_s = OC_AMOORW;
                        5'h0C: o_cand.op_s = OC_AMOANDW;
                        5'h10: o_cand.op_s = OC_AMOMINW;
                        5'h14: o_cand.op_s = OC_AMOMAXW;
                        5'h18: o_cand.op_s = OC_AMOMINUW;
                        5'h1C: o_cand.op_s = OC_AMOMAXUW;
                        default: o_cand.op_s = OC_NONE;
                    endcase
                end
            end
            OPC_LOADFP: begin
                if (i_fld.f3 == 3'd2) o_cand.op_s = OC_FLW;
                else if (i_fld.f3 == 3'd3) o_cand.op_s = OC_FLD;
            end
            OPC_STFP: begin
                if (i_fld.f3 == 3'd2) o_cand.op_s = OC_FSW;
                else if (i_fld.f3 == 3'd3) o_cand.op_s = OC_FSD;
            end
            OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
                o_cand.sel_s = (prec == 2'd0);
                o_cand.sel_d = (prec == 2'd1);
                case (i_fld.opc)
                    OPC_MADD:  begin o_cand.op_s = OC_FMADDS;  o_cand.op_d = OC_FMADDD;  end
                    OPC_MSUB:  begin o_cand.op_s = OC_FMSUBS;  o_cand.op_d = OC_FMSUBD;  end
                    OPC_NMSUB: begin o_cand.op_s = OC_FNMSUBS; o_cand.op_d = OC_FNMSUBD; end
                    default:   begin o_cand.op_s = OC_FNMADDS; o_cand.op_d = OC_FNMADDD; end
                endcase
            end
            OPC_OPFP: begin
                o_cand.sel_s = (prec == 2'd0);
                o_cand.sel_d = (prec == 2'd1);
                case (f5)
                    5'h00: begin o_cand.op_s = OC_FADDS; o_cand.op_d = OC_FADDD; end
                    5'h01: begin o_cand.op_s = OC_FSUBS; o_cand.op_d = OC_FSUBD; end
                    5'h02: begin o_cand.op_s = OC_FMULS; o_cand.op_d = OC_FMULD; end
                    5'h03: begin o_cand.op_s = OC_FDIVS; o_cand.op_d = OC_FDIVD; end
                    5'h0B: begin
                        if (i_fld.rs2 == 5'd0) begin
                            o_cand.op_s = OC_FSQRTS; o_cand.op_d = OC_FSQRTD;
                        end
                    end
                    5'h04: begin
                        case (i_fld.f3)
                            3'd0: begin o_cand.op_s = OC_FSGNJS;  o_cand.op_d = OC_FSGNJD;  end
                            3'd1: begin o_cand.op_s = OC_FSGNJNS; o_cand.op_d = OC_FSGNJND; end
                            3'd2: begin o_cand.op_s = OC_FSGNJXS; o_cand.op_d = OC_FSGNJXD; end
                            default: ;
                        endcase
                    end
                    5'h05: begin
                        if (i_fld.f3 == 3'd0) begin
                            o_cand.op_s = OC_FMINS; o_cand.op_d = OC_FMIND;
                        end else if (i_fld.f3 == 3'd1) begin
                            o_cand.op_s = OC_FMAXS; o_cand.op_d = OC_FMAXD;
                        end
                    end
                    5'h18: begin
                        if (i_fld.rs2 == 5'd0) begin
                            o_cand.op_s = OC_FCVTWS; o_cand.op_d = OC_FCVTWD;
                        end else if (i_fld.rs2 == 5'd1) begin
                            o_cand.op_s = OC_FCVTWUS; o_cand.op_d = OC_FCVTWUD;
                        end
                    end
                    5'h1C: begin
                        if (i_fld.rs2 == 5'd0 && i_fld.f3 == 3'd0) begin
                            o_cand.op_s = OC_FMVXW;
                        end else if (i_fld.rs2 == 5'd0 && i_fld.f3 == 3'd1) begin
                            o_cand.op_s = OC_FCLASSS; o_cand.op_d = OC_FCLASSD;
                        end
                    end
                    5'h14: begin
                        case (i_fld.f3)
                            3'd0: begin o_cand.op_s = OC_FLES; o_cand.op_d = OC_FLED; end
                            3'd1: begin o_cand.op_s = OC_FLTS; o_cand.op_d = OC_FLTD; end
                            3'd2: begin o_cand.op_s = OC_FEQS; o_cand.op_d = OC_FEQD; end
                            default: ;
                        endcase
                    end
                    5'h1A: begin
                        if (i_fld.rs2 == 5'd0) begin
                            o_cand.op_s = OC_FCVTSW; o_cand.op_d = OC_FCVTDW;
                        end else if (i_fld.rs2 == 5'd1) begin
                            o_cand.op_s = OC_FCVTSWU; o_cand.op_d = OC_FCVTDWU;
                        end
                    end
                    5'h1E: begin
                        if (i_fld.rs2 == 5'd0 && i_fld.f3 == 3'd0) o_cand.op_s = OC_FMVWX;
                    end
                    5'h08: begin
                        // conversion between precisions: the rs2 field names the source
                        if (i_fld.rs2 == 5'd1) o_cand.op_s = OC_FCVTSD;
                        if (i_fld.rs2 == 5'd0) o_cand.op_d = OC_FCVTDS;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/rv32_instruction_decoder.sv =====
// ============================================================================
// rv32_instruction_decoder
// Three-stage pipelined RV32IMAFD instruction decoder.
// ============================================================================
// The decoder takes one 32-bit instruction word per cycle on i_in and gives
// one decoded word per instruction on o_out, in order. A word accepted at a
// clock edge is captured by stage 1 at that edge, passes through stage 2, and
// its result is valid on o_out once stage 3 holds it; a new word may enter every
// cycle, so the rate is one word per cycle, set only by o_out readiness.
// Stage 1 registers the raw word and its format; stage 2 picks candidate
// operation codes and builds the immediate; stage 3 applies the precision
// choice and holds the result. A stall at o_out freezes all stages together,
// so nothing is dropped or repeated, and i_in.ready follows o_out readiness
// or a free output slot.
// ============================================================================
module rv32_instruction_decoder
    import rvdec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rvdec_word_if.sink   i_in,
    rvdec_word_if.source o_out
);
`include "assert_macros.svh"

    logic        adv;
    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_w1, r_w2;
    logic [2:0]  r_fk1, r_fk2;
    t_cand       r_cand2;
    logic [20:0] r_imm2;
    t_result     r_res3;
    t_fields     fld;
    t_cand       cand;
    logic [2:0]  n_fk;
    logic [20:0] n_imm;
    t_opcode     n_op;

    // Advance the whole pipe whenever the output slot is empty or drained.
    assign adv        = !r_v3 || o_out.ready;
    assign i_in.ready = adv;

    always_comb begin
        unique case (i_in.data[6:0])
            OPC_OP, OPC_AMO, OPC_OPFP, OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD:
                n_fk = FK_R;
            OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM, OPC_FENCE, OPC_LOADFP:
                n_fk = FK_I;
            OPC_STORE, OPC_STFP: n_fk = FK_S;
            OPC_BRANCH:          n_fk = FK_B;
            OPC_LUI, OPC_AUIPC:  n_fk = FK_U;
            OPC_JAL:             n_fk = FK_J;
            default:             n_fk = FK_NONE;
        endcase
    end

    // Stage 1: hold the raw word and its format.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in.valid;
        end
        if (adv) begin
            r_w1  <= i_in.data;
            r_fk1 <= n_fk;
        end
    end

    assign fld.opc   = r_w1[6:0];
    assign fld.f3    = r_w1[14:12];
    assign fld.f7    = r_w1[31:25];
    assign fld.rs2   = r_w1[24:20];
    assign fld.imm12 = r_w1[31:20];
    assign fld.fm    = r_w1[31:28];

    rvdec_opsel u_opsel (
        .i_fld  (fld),
        .o_cand (cand)
    );

    always_comb begin
        unique case (r_fk1)
            FK_I: n_imm = {{9{r_w1[31]}}, r_w1[31:20]};
            FK_S: n_imm = {{9{r_w1[31]}}, r_w1[31:25], r_w1[11:7]};
            FK_B: n_imm = {{8{r_w1[31]}}, r_w1[31], r_w1[7], r_w1[30:25], r_w1[11:8], 1'b0};
            FK_U: n_imm = {1'b0, r_w1[31:12]};
            FK_J: n_imm = {r_w1[31], r_w1[19:12], r_w1[20], r_w1[30:21], 1'b0};
            default: n_imm = '0;
        endcase
    end

    // Stage 2: hold candidates and immediate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_w2    <= r_w1;
            r_fk2   <= r_fk1;
            r_cand2 <= cand;
            r_imm2  <= n_imm;
        end
    end

    // Pick single or double candidate; drop to invalid on other precisions.
    always_comb begin
        if (r_cand2.sel_s)      n_op = r_cand2.op_s;
        else if (r_cand2.sel_d) n_op = r_cand2.op_d;
        else                    n_op = OC_NONE;
    end

    // Stage 3: output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
        if (adv) begin
            r_res3.opcode <= n_op;
            r_res3.format <= r_fk2;
            r_res3.imm    <= r_imm2;
            r_res3.rd     <= r_w2[11:7];
            r_res3.rs1    <= r_w2[19:15];
            r_res3.rs2    <= r_w2[24:20];
            r_res3.rs3    <= r_w2[31:27];
            r_res3.rm     <= r_w2[14:12];
            r_res3.aq     <= r_w2[26];
            r_res3.rl     <= r_w2[25];
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.data  = r_res3;

    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_v3 && !o_out.ready, r_v3 && $stable(r_res3), "stalled result changed")
    `ASSERT_ALWAYS(a_op_range, i_clk, i_rst_n, !r_v3 || r_res3.opcode <= OC_MRET, "operation code out of range")
    `ASSERT_ALWAYS(a_none_imm, i_clk, i_rst_n, !r_v3 || r_res3.format != FK_NONE || (r_res3.imm == '0 && r_res3.opcode == OC_NONE), "unknown opcode decoded")
    `ASSERT_NEXT(a_advance, i_clk, i_rst_n, adv && r_v2, r_v3, "pipeline lost a word")
endmodule

// ===== tb/rv32_instruction_decoder_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// rv32_instruction_decoder_test
// Self-checking bench for the pipelined RV32IMAFD decoder: a directed table
// of encodings followed by mostly well-formed random words. Every decoded
// word is compared field by field against an in-bench decoder or a typed-in value.
// ============================================================================
module rv32_instruction_decoder_test;
    import rvdec_pkg::*;

    localparam int RES_W      = $bits(t_result);
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_WORDS = 566;

    typedef struct {
        logic [31:0] word;
        bit          fixed;   // expected value typed in below
        t_result     exp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rvdec_word_if #(.W(32))    in_ch ();
    rvdec_word_if #(.W(RES_W)) out_ch ();

    rv32_instruction_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_result pending_q[$];    // decodes waiting to come out, oldest first
    t_row    dir_rows[$];
    int      errors = 0;
    int      words_in = 0;
    int      words_out = 0;
    int      cycles = 0;
    bit      no_gaps = 1'b0;  // burst mode: neither side idles
    bit      hold_out = 1'b0; // ask the receiver for a long stall

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    // Pick the single or double form from the two low funct7 bits.
    function automatic t_opcode by_prec(logic [1:0] prec, t_opcode s, t_opcode d);
        if (prec == 2'd0) return s;
        if (prec == 2'd1) return d;
        return OC_NONE;
    endfunction

    function automatic t_opcode opfp_op(logic [4:0] f5, logic [2:0] f3,
                                        logic [4:0] rs2, logic [1:0] prec);
        case (f5)
            5'h00: return by_prec(prec, OC_FADDS, OC_FADDD);
            5'h01: return by_prec(prec, OC_FSUBS, OC_FSUBD);
            5'h02: return by_prec(prec, OC_FMULS, OC_FMULD);
            5'h03: return by_prec(prec, OC_FDIVS, OC_FDIVD);
            5'h0B: return (rs2 == 0) ? by_prec(prec, OC_FSQRTS, OC_FSQRTD) : OC_NONE;
            5'h04: begin
                if (f3 == 0) return by_prec(prec, OC_FSGNJS, OC_FSGNJD);
                if (f3 == 1) return by_prec(prec, OC_FSGNJNS, OC_FSGNJND);
                if (f3 == 2) return by_prec(prec, OC_FSGNJXS, OC_FSGNJXD);
                return OC_NONE;
            end
            5'h05: begin
                if (f3 == 0) return by_prec(prec, OC_FMINS, OC_FMIND);
                if (f3 == 1) return by_prec(prec, OC_FMAXS, OC_FMAXD);
                return OC_NONE;
            end
            5'h18: begin
                if (rs2 == 0) return by_prec(prec, OC_FCVTWS, OC_FCVTWD);
                if (rs2 == 1) return by_prec(prec, OC_FCVTWUS, OC_FCVTWUD);
                return OC_NONE;
            end
            5'h1C: begin
                if (rs2 == 0 && f3 == 0 && prec == 0) return OC_FMVXW;
                if (rs2 == 0 && f3 == 1) return by_prec(prec, OC_FCLASSS, OC_FCLASSD);
                return OC_NONE;
            end
            5'h14: begin
                if (f3 == 0) return by_prec(prec, OC_FLES, OC_FLED);
                if (f3 == 1) return by_prec(prec, OC_FLTS, OC_FLTD);
                if (f3 == 2) return by_prec(prec, OC_FEQS, OC_FEQD);
                return OC_NONE;
            end
            5'h1A: begin
                if (rs2 == 0) return by_prec(prec, OC_FCVTSW, OC_FCVTDW);
                if (rs2 == 1) return by_prec(prec, OC_FCVTSWU, OC_FCVTDWU);
                return OC_NONE;
            end
            5'h1E: return (rs2 == 0 && f3 == 0 && prec == 0) ? OC_FMVWX : OC_NONE;
            5'h08: begin
                if (prec == 0 && rs2 == 1) return OC_FCVTSD;
                if (prec == 1 && rs2 == 0) return OC_FCVTDS;
                return OC_NONE;
            end
            default: return OC_NONE;
        endcase
    endfunction

    function automatic t_opcode amo_op(logic [4:0] f5, logic [4:0] rs2);
        case (f5)
            5'h00: return OC_AMOADDW;
            5'h01: return OC_AMOSWAPW;
            5'h02: return (rs2 == 0) ? OC_LRW : OC_NONE;
            5'h03: return OC_SCW;
            5'h04: return OC_AMOXORW;
            5'h08: return OC_AMOORW;
            5'h0C: return OC_AMOANDW;
            5'h10: return OC_AMOMINW;
            5'h14: return OC_AMOMAXW;
            5'h18: return OC_AMOMINUW;
            5'h1C: return OC_AMOMAXUW;
            default: return OC_NONE;
        endcase
    endfunction

    function automatic t_opcode operation_of(logic [31:0] w);
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [4:0] rs2;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        rs2 = w[24:20];
        case (opc)
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0: return OC_ADD;  3'd1: return OC_SLL;
                        3'd2: return OC_SLT;  3'd3: return OC_SLTU;
                        3'd4: return OC_XOR;  3'd5: return OC_SRL;
                        3'd6: return OC_OR;   default: return OC_AND;
                    endcase
                end
                if (f7 == F7_MUL) begin
                    case (f3)
                        3'd0: return OC_MUL;    3'd1: return OC_MULH;
                        3'd2: return OC_MULHSU; 3'd3: return OC_MULHU;
                        3'd4: return OC_DIV;    3'd5: return OC_DIVU;
                        3'd6: return OC_REM;    default: return OC_REMU;
                    endcase
                end
                if (f7 == F7_ALT && f3 == 0) return OC_SUB;
                if (f7 == F7_ALT && f3 == 5) return OC_SRA;
                return OC_NONE;
            end
            OPC_OPIMM: begin
                case (f3)
                    3'd0: return OC_ADDI;
                    3'd1: return (f7 == F7_BASE) ? OC_SLLI : OC_NONE;
                    3'd2: return OC_SLTI;
                    3'd3: return OC_SLTIU;
                    3'd4: return OC_XORI;
                    3'd5: begin
                        if (f7 == F7_BASE) return OC_SRLI;
                        if (f7 == F7_ALT) return OC_SRAI;
                        return OC_NONE;
                    end
                    3'd6: return OC_ORI;
                    default: return OC_ANDI;
                endcase
            end
            OPC_LOAD: begin
                case (f3)
                    3'd0: return OC_LB;  3'd1: return OC_LH;  3'd2: return OC_LW;
                    3'd4: return OC_LBU; 3'd5: return OC_LHU;
                    default: return OC_NONE;
                endcase
            end
            OPC_STORE: begin
                case (f3)
                    3'd0: return OC_SB; 3'd1: return OC_SH; 3'd2: return OC_SW;
                    default: return OC_NONE;
                endcase
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0: return OC_BEQ;  3'd1: return OC_BNE;
                    3'd4: return OC_BLT;  3'd5: return OC_BGE;
                    3'd6: return OC_BLTU; 3'd7: return OC_BGEU;
                    default: return OC_NONE;
                endcase
            end
            OPC_JAL:   return OC_JAL;
            OPC_JALR:  return (f3 == 0) ? OC_JALR : OC_NONE;
            OPC_LUI:   return OC_LUI;
            OPC_AUIPC: return OC_AUIPC;
            OPC_FENCE: begin
                if (f3 == 0) return (w[31:28] == FM_TSO) ? OC_FENCETSO : OC_FENCE;
                if (f3 == 1) return OC_FENCEI;
                return OC_NONE;
            end
            OPC_SYSTEM: begin
                case (f3)
                    3'd0: begin
                        case (w[31:20])
                            SYS_ECALL:  return OC_ECALL;
                            SYS_EBREAK: return OC_EBREAK;
                            SYS_WFI:    return OC_WFI;
                            SYS_MRET:   return OC_MRET;
                            default:    return OC_NONE;
                        endcase
                    end
                    3'd1: return OC_CSRRW;  3'd2: return OC_CSRRS;  3'd3: return OC_CSRRC;
                    3'd5: return OC_CSRRWI; 3'd6: return OC_CSRRSI; 3'd7: return OC_CSRRCI;
                    default: return OC_NONE;
                endcase
            end
            OPC_AMO:    return (f3 == 2) ? amo_op(f7[6:2], rs2) : OC_NONE;
            OPC_LOADFP: return (f3 == 2) ? OC_FLW : ((f3 == 3) ? OC_FLD : OC_NONE);
            OPC_STFP:   return (f3 == 2) ? OC_FSW : ((f3 == 3) ? OC_FSD : OC_NONE);
            OPC_MADD:   return by_prec(f7[1:0], OC_FMADDS, OC_FMADDD);
            OPC_MSUB:   return by_prec(f7[1:0], OC_FMSUBS, OC_FMSUBD);
            OPC_NMSUB:  return by_prec(f7[1:0], OC_FNMSUBS, OC_FNMSUBD);
            OPC_NMADD:  return by_prec(f7[1:0], OC_FNMADDS, OC_FNMADDD);
            OPC_OPFP:   return opfp_op(f7[6:2], f3, rs2, f7[1:0]);
            default:    return OC_NONE;
        endcase
    endfunction

    function automatic t_result decode_word(logic [31:0] w);
        t_result r;
        case (w[6:0])
            OPC_OP, OPC_AMO, OPC_OPFP, OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD:
                r.format = FK_R;
            OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM, OPC_FENCE, OPC_LOADFP:
                r.format = FK_I;
            OPC_STORE, OPC_STFP: r.format = FK_S;
            OPC_BRANCH:          r.format = FK_B;
            OPC_LUI, OPC_AUIPC:  r.format = FK_U;
            OPC_JAL:             r.format = FK_J;
            default:             r.format = FK_NONE;
        endcase
        case (r.format)
            FK_I: r.imm = {{9{w[31]}}, w[31:20]};
            FK_S: r.imm = {{9{w[31]}}, w[31:25], w[11:7]};
            FK_B: r.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            FK_U: r.imm = {1'b0, w[31:12]};   // left unshifted
            FK_J: r.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
            default: r.imm = '0;
        endcase
        r.opcode = operation_of(w);
        r.rd  = w[11:7];
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.rs3 = w[31:27];
        r.rm  = w[14:12];
        r.aq  = w[26];
        r.rl  = w[25];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        if (no_gaps) return 0;
        return $urandom_range(0, 11);
    endfunction

    // Mostly well-formed encodings with random content; a tenth raw noise.
    function automatic logic [31:0] random_word();
        logic [6:0] majors[19];
        logic [31:0] w;
        majors = '{OPC_OP, OPC_AMO, OPC_OPFP, OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD,
                   OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM, OPC_FENCE, OPC_LOADFP,
                   OPC_STORE, OPC_STFP, OPC_BRANCH, OPC_LUI, OPC_AUIPC, OPC_JAL};
        w = $urandom;
        if ($urandom_range(0, 9) == 0) return w;
        w[6:0] = majors[$urandom_range(0, 18)];
        // bias funct7 toward the values that select real operations
        case ($urandom_range(0, 4))
            0: w[31:25] = F7_BASE;
            1: w[31:25] = F7_MUL;
            2: w[31:25] = F7_ALT;
            3: w[26:25] = 2'($urandom_range(0, 1));
            default: ;
        endcase
        if ($urandom_range(0, 1)) w[24:20] = 5'($urandom_range(0, 1));
        if (w[6:0] == OPC_SYSTEM && $urandom_range(0, 1)) begin
            w[14:12] = 3'd0;
            case ($urandom_range(0, 3))
                0: w[31:20] = SYS_ECALL;
                1: w[31:20] = SYS_EBREAK;
                2: w[31:20] = SYS_WFI;
                default: w[31:20] = SYS_MRET;
            endcase
        end
        if (w[6:0] == OPC_FENCE && $urandom_range(0, 1)) w[31:28] = FM_TSO;
        if (w[6:0] == OPC_AMO && $urandom_range(0, 3) != 0) w[14:12] = 3'd2;
        return w;
    endfunction

    // Offer one word, hold it until taken, then queue its decode.
    task automatic send_word(logic [31:0] w, bit fixed, t_result exp);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_q.push_back(fixed ? exp : decode_word(w));
        words_in++;
    endtask

    task automatic add_row(logic [31:0] w, bit fixed, t_result exp);
        t_row row;
        row.word  = w;
        row.fixed = fixed;
        row.exp   = exp;
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_out = 1'b0;
            end
            n = draw_gap();
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each decoded word with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got, exp;
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = t_result'(out_ch.data);
            words_out++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected decoded word %h", $time, got);
                errors++;
            end else begin
                exp = pending_q.pop_front();
                if (got.opcode !== exp.opcode) begin
                    $display("%0t: opcode exp %0d got %0d", $time, exp.opcode, got.opcode);
                    errors++;
                end
                if (got.format !== exp.format) begin
                    $display("%0t: format exp %0d got %0d", $time, exp.format, got.format);
                    errors++;
                end
                if (got.imm !== exp.imm) begin
                    $display("%0t: imm exp %h got %h", $time, exp.imm, got.imm);
                    errors++;
                end
                if ({got.rd, got.rs1, got.rs2, got.rs3} !== {exp.rd, exp.rs1, exp.rs2, exp.rs3}) begin
                    $display("%0t: regs exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d", $time,
                             exp.rd, exp.rs1, exp.rs2, exp.rs3,
                             got.rd, got.rs1, got.rs2, got.rs3);
                    errors++;
                end
                if ({got.rm, got.aq, got.rl} !== {exp.rm, exp.aq, exp.rl}) begin
                    $display("%0t: rm/aq/rl exp %0d/%b/%b got %0d/%b/%b", $time,
                             exp.rm, exp.aq, exp.rl, got.rm, got.aq, got.rl);
                    errors++;
                end
            end
        end
    end

    // Watchdog: fail the run once the cycle counter passes CYCLE_CAP.
    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_result zero_res, ones_res, ecall_res, none_res;
        int settle;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        zero_res = '0;                     // unknown major opcode, all fields zero
        ones_res = '{opcode: 7'(OC_NONE), format: FK_NONE, imm: '0, rd: 5'd31,
                     rs1: 5'd31, rs2: 5'd31, rs3: 5'd31, rm: 3'd7, aq: 1'b1, rl: 1'b1};
        ecall_res = '0;
        ecall_res.opcode = 7'(OC_ECALL);
        ecall_res.format = FK_I;
        none_res = '0;

        add_row(32'h0000_0000, 1'b1, zero_res);
        add_row(32'hFFFF_FFFF, 1'b1, ones_res);
        add_row(32'h0000_0073, 1'b1, ecall_res);
        add_row(32'h0010_0073, 1'b0, none_res);   // ebreak
        add_row(32'h1050_0073, 1'b0, none_res);   // wfi
        add_row(32'h3020_0073, 1'b0, none_res);   // mret
        add_row(32'hFFF8_0073, 1'b0, none_res);   // system, unknown imm, rs1 set
        add_row(32'h0000_4073, 1'b0, none_res);   // system funct3 4 is invalid
        add_row(32'hFFFF_F037, 1'b0, none_res);   // lui, all-ones upper bits
        add_row(32'h8000_006F, 1'b0, none_res);   // jal, most negative offset
        add_row(32'h7FFF_F06F, 1'b0, none_res);   // jal, most positive offset
        add_row(32'hFE00_0FE3, 1'b0, none_res);   // branch, negative offset
        add_row(32'h8330_000F, 1'b0, none_res);   // fence.tso
        add_row(32'h0FF0_000F, 1'b0, none_res);   // plain fence
        add_row(32'h0000_100F, 1'b0, none_res);   // fence.i
        add_row(32'h4000_5013, 1'b0, none_res);   // srai
        add_row(32'h0200_1013, 1'b0, none_res);   // slli with bad funct7
        add_row(32'h0200_0053, 1'b0, none_res);   // fadd.d
        add_row(32'h0400_0053, 1'b0, none_res);   // precision 2 is invalid
        add_row(32'hE000_0053, 1'b0, none_res);   // fmv.x.w
        add_row(32'h4010_0053, 1'b0, none_res);   // fcvt.s.d
        add_row(32'h1000_202F, 1'b0, none_res);   // lr.w
        add_row(32'h1010_202F, 1'b0, none_res);   // lr.w with rs2 set is invalid
        add_row(32'h0600_202F, 1'b0, none_res);   // amoadd.w with aq and rl

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].exp);

        // Pause until the pipe drains, then stall the output and keep feeding.
        in_ch.valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge i_clk);
        no_gaps  = 1'b1;
        hold_out = 1'b1;
        for (int i = 0; i < 60; i++) send_word(random_word(), 1'b0, none_res);
        no_gaps = 1'b0;

        // Random phase, alternating between idling and full-rate stretches.
        for (int i = 0; i < RAND_WORDS; i++) begin
            if (i % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            send_word(random_word(), 1'b0, none_res);
        end
        in_ch.valid <= 1'b0;

        wait (pending_q.size() == 0);
        settle = 0;
        while (settle < 20) begin
            @(posedge i_clk);
            settle++;
        end

        $display("Decoded %0d words (%0d in) across all major opcodes, stalls and bursts",
                 words_out, words_in);
        $display("Checked %0d cycles with %0d field mismatches", cycles, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
